/* rtl/bmhq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhq_pkg: shared types and codes of the binary min-heap queue
// Operation and status codes, controller states and the command and status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package bmhq_pkg;

  localparam logic [1:0] ACT_INSERT   = 2'd0;
  localparam logic [1:0] ACT_REMOVE   = 2'd1;
  localparam logic [1:0] ACT_CONTAINS = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,     // read the parent of the hole
    S_UP_CMP,    // compare with the parent, move it down or place the entry
    S_RM_RD,     // capture the root and read the last entry
    S_RM_LAST,   // capture the last entry
    S_DN_RD,     // read the left child of the hole, or place the entry
    S_DN_R,      // capture the left child, read the right child if any
    S_DN_CMP,    // capture the right child and compare
    S_SR_RD,     // dispatch on the action; a tag search reads its first slot
    S_SR_CMP,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the input item
    logic rd_parent;  // read parent of pos
    logic rd_root;    // read slot 1
    logic rd_last;    // read slot count
    logic rd_left;    // read slot 2*pos
    logic rd_right;   // read slot 2*pos+1
    logic rd_scan;    // read scan slot
    logic cap_out;    // capture root as the removed minimum
    logic cap_ent;    // capture the read entry as the sifting entry
    logic cap_left;   // capture the read entry as left child
    logic move_par;   // write parent into pos, pos <= parent
    logic move_child; // write the chosen child into pos, pos <= child
    logic place;      // write sifting entry into pos
    logic cnt_inc;
    logic cnt_dec;
    logic scan_next;
    logic set_found;
    logic set_full;
    logic set_empty;
    logic start_up;   // pos <= count + 1
    logic start_dn;   // pos <= 1
    logic start_scan;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] action;
    logic       full;
    logic       empty;
    logic       at_root;     // pos is 1
    logic       less_par;    // entry < read parent
    logic       no_child;    // 2*pos > count
    logic       has_right;   // 2*pos < count
    logic       child_less;  // chosen child < entry
    logic       last_one;    // count is 1 before remove
    logic       tag_hit;
    logic       scan_end;    // scan index past count
  } stat_t;

endpackage

/* rtl/bmhq_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhq_ctrl: controller of the binary min-heap queue
// Sequences insert, remove and search over the datapath and runs the
// input and output handshakes.
// ----------------------------------------------------------------------------
module bmhq_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  bmhq_pkg::stat_t st,
  output bmhq_pkg::cmd_t  cmd
);

  bmhq_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bmhq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall  = (state_r != bmhq_pkg::S_IDLE);
  assign out_valid = (state_r == bmhq_pkg::S_DONE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      bmhq_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = bmhq_pkg::S_DONE;
          // Dispatch happens next state on the latched item.
          state_nxt = bmhq_pkg::S_SR_RD;
        end
      end
      bmhq_pkg::S_SR_RD: begin
        // First cycle after capture: dispatch on the action.
        unique case (st.action)
          bmhq_pkg::ACT_INSERT: begin
            if (st.full) begin
              cmd.set_full = 1'b1;
              state_nxt    = bmhq_pkg::S_DONE;
            end else begin
              cmd.start_up = 1'b1;
              cmd.cnt_inc  = 1'b1;
              state_nxt    = bmhq_pkg::S_UP_RD;
            end
          end
          bmhq_pkg::ACT_REMOVE: begin
            if (st.empty) begin
              cmd.set_empty = 1'b1;
              state_nxt     = bmhq_pkg::S_DONE;
            end else begin
              cmd.rd_root = 1'b1;
              state_nxt   = bmhq_pkg::S_RM_RD;
            end
          end
          bmhq_pkg::ACT_CONTAINS: begin
            cmd.start_scan = 1'b1;
            cmd.rd_scan    = 1'b1;
            state_nxt      = bmhq_pkg::S_SR_CMP;
          end
          default: state_nxt = bmhq_pkg::S_DONE;
        endcase
      end
      bmhq_pkg::S_UP_RD: begin
        if (st.at_root) begin
          cmd.place = 1'b1;
          state_nxt = bmhq_pkg::S_DONE;
        end else begin
          cmd.rd_parent = 1'b1;
          state_nxt     = bmhq_pkg::S_UP_CMP;
        end
      end
      bmhq_pkg::S_UP_CMP: begin
        if (st.less_par) begin
          cmd.move_par = 1'b1;
          state_nxt    = bmhq_pkg::S_UP_RD;
        end else begin
          cmd.place = 1'b1;
          state_nxt = bmhq_pkg::S_DONE;
        end
      end
      bmhq_pkg::S_RM_RD: begin
        cmd.cap_out = 1'b1;
        cmd.rd_last = 1'b1;
        state_nxt   = bmhq_pkg::S_RM_LAST;
      end
      bmhq_pkg::S_RM_LAST: begin
        cmd.cap_ent  = 1'b1;
        cmd.cnt_dec  = 1'b1;
        cmd.start_dn = 1'b1;
        state_nxt    = st.last_one ? bmhq_pkg::S_DONE : bmhq_pkg::S_DN_RD;
      end
      bmhq_pkg::S_DN_RD: begin
        if (st.no_child) begin
          cmd.place = 1'b1;
          state_nxt = bmhq_pkg::S_DONE;
        end else begin
          cmd.rd_left = 1'b1;
          state_nxt   = bmhq_pkg::S_DN_R;
        end
      end
      bmhq_pkg::S_DN_R: begin
        cmd.cap_left = 1'b1;
        cmd.rd_right = st.has_right;
        state_nxt    = bmhq_pkg::S_DN_CMP;
      end
      bmhq_pkg::S_DN_CMP: begin
        if (st.child_less) begin
          cmd.move_child = 1'b1;
          state_nxt      = bmhq_pkg::S_DN_RD;
        end else begin
          cmd.place = 1'b1;
          state_nxt = bmhq_pkg::S_DONE;
        end
      end
      bmhq_pkg::S_SR_CMP: begin
        if (st.scan_end) begin
          state_nxt = bmhq_pkg::S_DONE;
        end else if (st.tag_hit) begin
          cmd.set_found = 1'b1;
          state_nxt     = bmhq_pkg::S_DONE;
        end else begin
          cmd.scan_next = 1'b1;
          cmd.rd_scan   = 1'b1;
        end
      end
      bmhq_pkg::S_DONE: begin
        if (!out_stall) begin
          state_nxt = bmhq_pkg::S_IDLE;
        end
      end
      default: state_nxt = bmhq_pkg::S_IDLE;
    endcase
  end

endmodule

/* rtl/bmhq_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhq_dp: datapath of the binary min-heap queue
// Heap memory with one registered read port, slot pointer, entry count,
// comparators and result registers.
// ----------------------------------------------------------------------------
module bmhq_dp #(
  parameter int DEPTH          = 64,
  parameter int PRIORITY_WIDTH = 32,
  parameter int TAG_WIDTH      = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [1:0]                    in_action,
  input  logic [PRIORITY_WIDTH-1:0]     in_priority_req,
  input  logic [TAG_WIDTH-1:0]          in_tag,
  input  bmhq_pkg::cmd_t                cmd,
  output bmhq_pkg::stat_t               st,
  output logic [1:0]                    status,
  output logic                          found,
  output logic [PRIORITY_WIDTH-1:0]     out_priority,
  output logic [TAG_WIDTH-1:0]          out_tag,
  output logic [$clog2(DEPTH+1)-1:0]    count
);

  localparam int AW = $clog2(DEPTH + 1);   // holds 0..DEPTH
  localparam int MW = $clog2(DEPTH);       // memory index
  localparam int EW = PRIORITY_WIDTH + TAG_WIDTH;

  // Slot s (1-based) lives at memory address s-1.
  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rd_data_r;

  logic [1:0]          act_r;
  logic [EW-1:0]       ent_r;
  logic [EW-1:0]       left_r;
  logic [AW-1:0]       pos_r, cnt_r, scan_r;
  logic [1:0]          status_r;
  logic                found_r;
  logic [PRIORITY_WIDTH-1:0] op_r;
  logic [TAG_WIDTH-1:0]      ot_r;

  logic [AW:0]   lchild;
  logic [AW-1:0] parent;
  logic [AW-1:0] rd_slot;
  logic          rd_en;
  logic [AW-1:0] wr_slot;
  logic [EW-1:0] wr_data;
  logic          wr_en;
  logic [EW-1:0] child;
  logic          right_less;
  logic          has_right_r;

  function automatic logic [PRIORITY_WIDTH-1:0] prio_of(input logic [EW-1:0] e);
    prio_of = e[EW-1:TAG_WIDTH];
  endfunction

  assign lchild = {pos_r, 1'b0};
  assign parent = pos_r >> 1;

  // Right child wins only when strictly smaller than the left.
  assign right_less = has_right_r && (prio_of(rd_data_r) < prio_of(left_r));
  assign child      = right_less ? rd_data_r : left_r;

  always_comb begin
    rd_en   = 1'b1;
    rd_slot = AW'(1);
    priority if (cmd.rd_parent) rd_slot = parent;
    else if (cmd.rd_last)       rd_slot = cnt_r;
    else if (cmd.rd_left)       rd_slot = lchild[AW-1:0];
    else if (cmd.rd_right)      rd_slot = AW'(lchild + 1'b1);
    else if (cmd.rd_scan)       rd_slot = cmd.start_scan ? AW'(1) : AW'(scan_r + 1'b1);
    else if (cmd.rd_root)       rd_slot = AW'(1);
    else                        rd_en   = 1'b0;
  end

  always_comb begin
    wr_en   = cmd.move_par | cmd.move_child | cmd.place;
    wr_slot = pos_r;
    wr_data = ent_r;
    if (cmd.move_par)   wr_data = rd_data_r;
    if (cmd.move_child) wr_data = child;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[MW'(rd_slot - 1'b1)];
    end
    if (wr_en) begin
      mem[MW'(wr_slot - 1'b1)] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + 1'b1;
    end else if (cmd.cnt_dec) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r    <= in_action;
      ent_r    <= {in_priority_req, in_tag};
      status_r <= bmhq_pkg::ST_OK;
      found_r  <= 1'b0;
      op_r     <= '0;
      ot_r     <= '0;
    end
    if (cmd.set_full)  status_r <= bmhq_pkg::ST_FULL;
    if (cmd.set_empty) status_r <= bmhq_pkg::ST_EMPTY;
    if (cmd.set_found) found_r  <= 1'b1;
    if (cmd.cap_out) begin
      op_r <= prio_of(rd_data_r);
      ot_r <= rd_data_r[TAG_WIDTH-1:0];
    end
    if (cmd.cap_ent)  ent_r  <= rd_data_r;
    if (cmd.cap_left) begin
      left_r      <= rd_data_r;
      has_right_r <= cmd.rd_right;
    end
    if (cmd.start_up) pos_r <= AW'(cnt_r + 1'b1);
    if (cmd.start_dn) pos_r <= AW'(1);
    if (cmd.move_par) pos_r <= parent;
    if (cmd.move_child) pos_r <= right_less ? AW'(lchild + 1'b1) : lchild[AW-1:0];
    if (cmd.start_scan) scan_r <= AW'(1);
    if (cmd.scan_next)  scan_r <= AW'(scan_r + 1'b1);
  end

  assign st.action     = act_r;
  assign st.full       = (cnt_r >= AW'(DEPTH));
  assign st.empty      = (cnt_r == '0);
  assign st.at_root    = (pos_r == AW'(1));
  assign st.less_par   = prio_of(ent_r) < prio_of(rd_data_r);
  assign st.no_child   = (lchild > {1'b0, cnt_r});
  assign st.has_right  = (lchild < {1'b0, cnt_r});
  assign st.child_less = prio_of(child) < prio_of(ent_r);
  assign st.last_one   = (cnt_r == AW'(1));
  assign st.tag_hit    = (rd_data_r[TAG_WIDTH-1:0] == ent_r[TAG_WIDTH-1:0]);
  assign st.scan_end   = (scan_r > cnt_r);

  assign status       = status_r;
  assign found        = found_r;
  assign out_priority = op_r;
  assign out_tag      = ot_r;
  assign count        = cnt_r;

endmodule

/* rtl/binary_min_heap_queue.sv */
`timescale 1ns / 1ps
// Insert climbs the new entry one level at a time and may stop below the root; remove
// ends at once with one entry, else descends the last entry one level at a time and may
// stop above a leaf; contains compares slots until a hit or until all entries are read;
// full, empty and unused codes end at dispatch. Throughput: one item at a time, the next
// one taken only after the result leaves.
// Reset (rst_n low, synchronous) empties the heap; memory contents stay as they are.
// ----------------------------------------------------------------------------
// binary_min_heap_queue: bounded min-heap priority queue
// Insert, remove-minimum and tag search over a 1-based heap held in memory.
// ----------------------------------------------------------------------------
module binary_min_heap_queue #(
  parameter int DEPTH          = 64,
  parameter int PRIORITY_WIDTH = 32,
  parameter int TAG_WIDTH      = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_action,
  input  logic [PRIORITY_WIDTH-1:0]     in_priority_req,
  input  logic [TAG_WIDTH-1:0]          in_tag,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_status,
  output logic                          out_found,
  output logic [PRIORITY_WIDTH-1:0]     out_out_priority,
  output logic [TAG_WIDTH-1:0]          out_out_tag,
  output logic [$clog2(DEPTH+1)-1:0]    out_count
);

  localparam int CW = $clog2(DEPTH + 1);

  // The controller walks the heap one memory access per cycle; the
  // datapath owns the memory, the slot pointer and the comparators.
  bmhq_pkg::cmd_t  cmd;
  bmhq_pkg::stat_t st;

  bmhq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  bmhq_dp #(
    .DEPTH          (DEPTH),
    .PRIORITY_WIDTH (PRIORITY_WIDTH),
    .TAG_WIDTH      (TAG_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_action       (in_action),
    .in_priority_req (in_priority_req),
    .in_tag          (in_tag),
    .cmd             (cmd),
    .st              (st),
    .status          (out_status),
    .found           (out_found),
    .out_priority    (out_out_priority),
    .out_tag         (out_out_tag),
    .count           (out_count)
  );

  // The entry count never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_count <= CW'(DEPTH)) else $error("heap count above capacity");

  // A result holds while the receiver stalls it.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_count))
    else $error("result dropped under stall");

  // No new item is taken while a result is pending.
  a_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("item accepted while result pending");

endmodule
